>>> rtl/bgcd_pkg.sv
// ---------------------------------------------------------------------------
// Binary GCD package
// Shared constants and the command and status types that pass between the
// controller and the datapath of the binary GCD block.
// ---------------------------------------------------------------------------
package bgcd_pkg;

	localparam int DEF_WIDTH = 16;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;      // capture a new request into the working registers
		logic step;      // one shift or subtract step of the reduction
		logic load_out;  // capture the final divisor into the output register
	} bgcd_cmd_t;

	// Status from the datapath back to the controller.
	typedef struct packed {
		logic zero;      // one of the operands of this request was zero
		logic a_odd;
		logic b_odd;
		logic equal;     // both working values are the same
	} bgcd_status_t;

endpackage

>>> rtl/bgcd_req_if.sv
// ---------------------------------------------------------------------------
// Binary GCD request channel
// Carries one pair of operands with a valid and ready handshake.
// ---------------------------------------------------------------------------
interface bgcd_req_if #(
	parameter int WIDTH = bgcd_pkg::DEF_WIDTH
);
	logic             valid;
	logic             ready;
	logic [WIDTH-1:0] operand_a;
	logic [WIDTH-1:0] operand_b;

	modport source (output valid, output operand_a, output operand_b, input ready);
	modport sink   (input valid, input operand_a, input operand_b, output ready);
endinterface

>>> rtl/bgcd_rsp_if.sv
// ---------------------------------------------------------------------------
// Binary GCD response channel
// Carries one divisor with a valid and ready handshake.
// ---------------------------------------------------------------------------
interface bgcd_rsp_if #(
	parameter int WIDTH = bgcd_pkg::DEF_WIDTH
);
	logic             valid;
	logic             ready;
	logic [WIDTH-1:0] divisor;

	modport source (output valid, output divisor, input ready);
	modport sink   (input valid, input divisor, output ready);
endinterface

>>> rtl/binary_gcd.sv
// ---------------------------------------------------------------------------
// Binary GCD
// Greatest common divisor of two unsigned operands by Stein's algorithm.
// ---------------------------------------------------------------------------
// The block takes one request of two WIDTH-bit unsigned operands and returns
// one divisor of the same width, the greatest common divisor, or zero when
// either operand is zero. Requests are handled one at a time: the request
// channel is ready only while the controller is idle. The datapath performs
// a single shift-or-subtract step per cycle: each cycle either halves one or
// both working values (counting common factors of two) or replaces the
// larger odd value by the difference. When the reduction ends and the output
// register is free, the divisor is loaded, and the request channel is ready
// again in the cycle after. A zero operand or equal odd operands need no step
// at all. The worst case is about 3*WIDTH steps: at WIDTH 16 the pair 0x8000
// and 0xFFFF takes 45 steps, 15 halvings of the even operand followed by 15
// subtractions that are each followed by a single halving. The final shift
// back by the common count happens in the cycle that loads the output
// register. The output register lets the block take the next request while
// an earlier divisor still waits on the response channel; a finished
// reduction holds only if that divisor has not yet been taken.
// ---------------------------------------------------------------------------
module binary_gcd #(
	parameter int WIDTH = bgcd_pkg::DEF_WIDTH
) (
	input logic       clk,
	input logic       arst_n,
	bgcd_req_if.sink  req,
	bgcd_rsp_if.source rsp
);
	import bgcd_pkg::*;

	bgcd_cmd_t    cmd;
	bgcd_status_t status;

	// The controller sequences each request and owns both handshakes.
	bgcd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.status    (status),
		.cmd       (cmd)
	);

	// The datapath holds the working values, the count of common factors of
	// two and the output register.
	bgcd_dp #(
		.WIDTH (WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.operand_a (req.operand_a),
		.operand_b (req.operand_b),
		.cmd       (cmd),
		.status    (status),
		.divisor   (rsp.divisor)
	);

endmodule

>>> rtl/bgcd_dp.sv
// ---------------------------------------------------------------------------
// Binary GCD datapath
// Working registers, the shift and subtract step, the count of common
// factors of two and the output register.
// ---------------------------------------------------------------------------
module bgcd_dp #(
	parameter int WIDTH = bgcd_pkg::DEF_WIDTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [WIDTH-1:0]       operand_a,
	input  logic [WIDTH-1:0]       operand_b,
	input  bgcd_pkg::bgcd_cmd_t    cmd,
	output bgcd_pkg::bgcd_status_t status,
	output logic [WIDTH-1:0]       divisor
);
	import bgcd_pkg::*;

	localparam int CNT_W = (WIDTH > 2) ? $clog2(WIDTH) : 1;

	logic [WIDTH-1:0] a_q;
	logic [WIDTH-1:0] b_q;
	logic [CNT_W-1:0] cnt_q;
	logic             zero_q;
	logic [WIDTH-1:0] out_q;

	assign status.zero  = zero_q;
	assign status.a_odd = a_q[0];
	assign status.b_odd = b_q[0];
	assign status.equal = (a_q == b_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q    <= '0;
			b_q    <= '0;
			cnt_q  <= '0;
			zero_q <= 1'b0;
		end else if (cmd.load) begin
			a_q    <= operand_a;
			b_q    <= operand_b;
			cnt_q  <= '0;
			zero_q <= (operand_a == '0) || (operand_b == '0);
		end else if (cmd.step) begin
			if (!a_q[0] && !b_q[0]) begin
				// A factor of two common to both values.
				a_q   <= a_q >> 1;
				b_q   <= b_q >> 1;
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (!a_q[0]) begin
				a_q <= a_q >> 1;
			end else if (!b_q[0]) begin
				b_q <= b_q >> 1;
			end else if (a_q > b_q) begin
				a_q <= a_q - b_q;
			end else begin
				b_q <= b_q - a_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_q <= '0;
		end else if (cmd.load_out) begin
			out_q <= zero_q ? '0 : (a_q << cnt_q);
		end
	end

	assign divisor = out_q;

endmodule

>>> rtl/bgcd_ctrl.sv
// ---------------------------------------------------------------------------
// Binary GCD controller
// Sequences one request through load, reduction and output, and owns both
// handshakes.
// ---------------------------------------------------------------------------
module bgcd_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  logic                   out_ready,
	input  bgcd_pkg::bgcd_status_t status,
	output bgcd_pkg::bgcd_cmd_t    cmd
);
	import bgcd_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;
	logic       done;
	logic       accept;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;

	// Reduction ends at once on a zero operand, else when both odd values meet.
	assign done = status.zero || (status.a_odd && status.b_odd && status.equal);

	always_comb begin
		state_d      = state_q;
		cmd.load     = 1'b0;
		cmd.step     = 1'b0;
		cmd.load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_RUN;
				end
			end
			ST_RUN: begin
				if (done) begin
					state_d = ST_FIN;
				end else begin
					cmd.step = 1'b1;
				end
			end
			ST_FIN: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// The output register is never overwritten while its divisor waits.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || out_ready))
		else $error("output register overwritten while full");

	// An accepted request always starts the reduction.
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_RUN))
		else $error("accepted request did not start");

	// A zero operand skips the reduction entirely.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) && status.zero |-> !cmd.step)
		else $error("step issued on a zero operand");

	// Loading the output always returns the controller to idle.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> (state_q == ST_IDLE) && out_valid_q)
		else $error("output load did not complete");

endmodule
